/* design/tekd_pkg.sv */
// ---------------------------------------------------------------------------
// tekd_pkg
// Shared types, codes and lookup functions for the terminal key decoder.
// ---------------------------------------------------------------------------
package tekd_pkg;

  // decode modes
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_ESC  = 2'd1;
  localparam logic [1:0] MODE_SS3  = 2'd2;
  localparam logic [1:0] MODE_CSI  = 2'd3;

  // request kinds
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // key codes
  localparam logic [3:0] KC_NONE  = 4'd0;
  localparam logic [3:0] KC_ENTER = 4'd1;
  localparam logic [3:0] KC_BACK  = 4'd2;
  localparam logic [3:0] KC_CHAR  = 4'd3;
  localparam logic [3:0] KC_ESC   = 4'd4;
  localparam logic [3:0] KC_UP    = 4'd5;
  localparam logic [3:0] KC_DOWN  = 4'd6;
  localparam logic [3:0] KC_RIGHT = 4'd7;
  localparam logic [3:0] KC_LEFT  = 4'd8;
  localparam logic [3:0] KC_HOME  = 4'd9;
  localparam logic [3:0] KC_END   = 4'd10;
  localparam logic [3:0] KC_PGUP  = 4'd11;
  localparam logic [3:0] KC_PGDN  = 4'd12;

  // byte values
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SS3    = 8'h4F;
  localparam logic [7:0] CH_CSI    = 8'h5B;
  localparam logic [7:0] CH_TILDE  = 8'h7E;
  localparam logic [7:0] CH_DEL    = 8'h7F;

  localparam logic [15:0] TIMEOUT_RESET = 16'd25;
  localparam logic [15:0] WAIT_MAX      = 16'hFFFF;
  localparam logic [8:0]  CHAR_NONE     = 9'h1FF;
  localparam logic [7:0]  NUM_MAX       = 8'd255;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] wait_count;
    logic [7:0]  number;
    logic        number_done;
    logic [8:0]  saved_char;
  } tekd_state_t;

  typedef struct packed {
    logic       emit;
    logic [3:0] key_code;
  } tekd_result_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= CH_SPACE) && (b <= CH_TILDE);
  endfunction

  function automatic logic [3:0] arrow_key(input logic [7:0] b);
    logic [3:0] k;
    unique case (b)
      8'h41:   k = KC_UP;
      8'h42:   k = KC_DOWN;
      8'h43:   k = KC_RIGHT;
      8'h44:   k = KC_LEFT;
      8'h48:   k = KC_HOME;
      8'h46:   k = KC_END;
      default: k = KC_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [3:0] tilde_key(input logic [7:0] n);
    logic [3:0] k;
    unique case (n)
      8'd1, 8'd7: k = KC_HOME;
      8'd4, 8'd8: k = KC_END;
      8'd5:       k = KC_PGUP;
      8'd6:       k = KC_PGDN;
      8'd3:       k = KC_BACK;
      default:    k = KC_NONE;
    endcase
    return k;
  endfunction

endpackage

/* design/tekd_step.sv */
// ---------------------------------------------------------------------------
// tekd_step
// Next-state and key decode for one byte or tick request.
// ---------------------------------------------------------------------------
module tekd_step #(
  parameter int MAX_PARAM_BYTES = 7,
  parameter int PW = $clog2(MAX_PARAM_BYTES + 1)
) (
  input  logic                 cmd,
  input  logic [7:0]           data_byte,
  input  logic [15:0]          timeout_ticks,
  input  tekd_pkg::tekd_state_t cur,
  input  logic [PW-1:0]        pkept,
  output tekd_pkg::tekd_state_t nxt,
  output logic [PW-1:0]        pkept_next,
  output tekd_pkg::tekd_result_t res
);

  logic [15:0] lim;
  logic [15:0] wc;
  logic [11:0] num_mac;
  logic        is_digit;

  assign lim      = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
  assign wc       = (cur.wait_count < tekd_pkg::WAIT_MAX) ?
                    cur.wait_count + 16'd1 : cur.wait_count;
  assign is_digit = (data_byte >= tekd_pkg::CH_ZERO) && (data_byte <= tekd_pkg::CH_NINE);
  assign num_mac  = {1'b0, cur.number, 3'b000} + {3'b000, cur.number, 1'b0}
                  + {4'd0, data_byte - tekd_pkg::CH_ZERO};

  always_comb begin
    nxt          = cur;
    pkept_next   = pkept;
    res.emit     = 1'b0;
    res.key_code = tekd_pkg::KC_NONE;
    if (cmd == tekd_pkg::CMD_TICK) begin
      if (cur.mode != tekd_pkg::MODE_IDLE) begin
        nxt.wait_count = wc;
        if (wc >= lim) begin
          res.emit     = 1'b1;
          res.key_code = (cur.mode == tekd_pkg::MODE_ESC) ? tekd_pkg::KC_ESC
                                                          : tekd_pkg::KC_NONE;
        end
      end
    end else begin
      nxt.wait_count = 16'd0;
      unique case (cur.mode)
        tekd_pkg::MODE_IDLE: begin
          if (data_byte == tekd_pkg::CH_CR || data_byte == tekd_pkg::CH_LF) begin
            res.emit     = 1'b1;
            res.key_code = tekd_pkg::KC_ENTER;
          end else if (data_byte == tekd_pkg::CH_DEL || data_byte == tekd_pkg::CH_BS) begin
            res.emit     = 1'b1;
            res.key_code = tekd_pkg::KC_BACK;
          end else if (data_byte == tekd_pkg::CH_ESC) begin
            nxt.mode = tekd_pkg::MODE_ESC;
          end else if (tekd_pkg::is_printable(data_byte)) begin
            nxt.saved_char = {1'b0, data_byte};
            res.emit       = 1'b1;
            res.key_code   = tekd_pkg::KC_CHAR;
          end else begin
            res.emit = 1'b1;
          end
        end
        tekd_pkg::MODE_ESC: begin
          if (data_byte == tekd_pkg::CH_SS3) begin
            nxt.mode = tekd_pkg::MODE_SS3;
          end else if (data_byte == tekd_pkg::CH_CSI) begin
            nxt.mode        = tekd_pkg::MODE_CSI;
            nxt.number      = 8'd0;
            nxt.number_done = 1'b0;
            pkept_next      = '0;
          end else begin
            nxt.saved_char = {1'b0, data_byte};
            res.emit       = 1'b1;
            res.key_code   = tekd_pkg::is_printable(data_byte) ? tekd_pkg::KC_CHAR
                                                               : tekd_pkg::KC_ESC;
          end
        end
        tekd_pkg::MODE_SS3: begin
          res.emit     = 1'b1;
          res.key_code = tekd_pkg::arrow_key(data_byte);
        end
        tekd_pkg::MODE_CSI: begin
          if (is_digit || data_byte == tekd_pkg::CH_SEMI) begin
            if (pkept < PW'(MAX_PARAM_BYTES)) begin
              pkept_next = pkept + PW'(1);
              if (!cur.number_done) begin
                if (data_byte == tekd_pkg::CH_SEMI) begin
                  nxt.number_done = 1'b1;
                end else begin
                  nxt.number = (num_mac > 12'd255) ? tekd_pkg::NUM_MAX : num_mac[7:0];
                end
              end
            end
          end else if (data_byte == tekd_pkg::CH_TILDE) begin
            res.emit     = 1'b1;
            res.key_code = tekd_pkg::tilde_key(cur.number);
          end else begin
            res.emit     = 1'b1;
            res.key_code = tekd_pkg::arrow_key(data_byte);
          end
        end
        default: begin
          res.emit = 1'b1;
        end
      endcase
    end
    if (res.emit) begin
      nxt.mode       = tekd_pkg::MODE_IDLE;
      nxt.wait_count = 16'd0;
    end
  end

endmodule

/* design/terminal_escape_key_decoder_core.sv */
// ---------------------------------------------------------------------------
// terminal_escape_key_decoder_core
// Decodes terminal input bytes and tick requests into key presses.
// ---------------------------------------------------------------------------
// Takes one request per clock while the output is not stalled: a request is
// registered in the input register, decoded against the decode state, and any
// key it gives lands in the output register. The loop through the decode
// state register sets the rate of one request per cycle; the output register
// stalls the input only while a key waits and m_axis_tready is low.
module terminal_escape_key_decoder_core #(
  parameter int MAX_PARAM_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,      // timeout_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // key_code[3:0], last_char[12:4], zero[15:13]
);

  localparam int PW = $clog2(MAX_PARAM_BYTES + 1);

  logic                  in_valid;
  logic                  in_cmd;
  logic [7:0]            in_byte;
  logic                  advance;
  logic [15:0]           timeout_ticks;
  tekd_pkg::tekd_state_t state;
  tekd_pkg::tekd_state_t state_next;
  logic [PW-1:0]         pkept;
  logic [PW-1:0]         pkept_next;
  tekd_pkg::tekd_result_t res;
  logic [3:0]            out_key;
  logic [8:0]            out_char;

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= tekd_pkg::TIMEOUT_RESET;
    end else if (cfg_wen) begin
      timeout_ticks <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd  <= s_axis_tuser;
      in_byte <= s_axis_tdata;
    end
  end

  tekd_step #(
    .MAX_PARAM_BYTES(MAX_PARAM_BYTES),
    .PW(PW)
  ) u_step (
    .cmd          (in_cmd),
    .data_byte    (in_byte),
    .timeout_ticks(timeout_ticks),
    .cur          (state),
    .pkept        (pkept),
    .nxt          (state_next),
    .pkept_next   (pkept_next),
    .res          (res)
  );

  // decode state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode        <= tekd_pkg::MODE_IDLE;
      state.wait_count  <= 16'd0;
      state.number      <= 8'd0;
      state.number_done <= 1'b0;
      state.saved_char  <= tekd_pkg::CHAR_NONE;
      pkept             <= '0;
    end else if (advance) begin
      state <= state_next;
      pkept <= pkept_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res.emit;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_key  <= res.key_code;
      out_char <= state_next.saved_char;
    end
  end

  assign m_axis_tdata = {3'b000, out_char, out_key};

endmodule

/* design/tekd_checker.sv */
// ---------------------------------------------------------------------------
// tekd_checker
// Port-level checks for the terminal key decoder, bound to the top level.
// ---------------------------------------------------------------------------
module tekd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // a stalled key stays valid
  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("key dropped while stalled");

  // no key right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !m_axis_tvalid)
    else $error("key valid right after reset");

  // key codes stay in range
  a_key_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[3:0] <= tekd_pkg::KC_PGDN)
    else $error("key code out of range");

  // a char key always carries a printable last char
  a_char_printable: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[3:0] == tekd_pkg::KC_CHAR |->
      m_axis_tdata[12:4] >= 9'd32 && m_axis_tdata[12:4] <= 9'd126)
    else $error("char key without printable char");

endmodule

bind terminal_escape_key_decoder_core tekd_checker u_tekd_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

/* dv/tekd_key_checker.sv */
// ---------------------------------------------------------------------------
// tekd_key_checker
// Watches the configuration port and both streams of the terminal key
// decoder. It keeps its own copy of the decode state, works out the key
// that each accepted request should give, and checks every key that leaves
// the block, field by field, against the oldest one still due.
// ---------------------------------------------------------------------------
module tekd_key_checker #(
  parameter int MAX_PARAM_BYTES = 7
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wen,
  input  logic [15:0] cfg_wdata,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic        s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [15:0] m_axis_tdata,
  output int          fail_count,
  output int          keys_pending,
  output int          keys_checked
);

  // final bytes of cursor sequences
  localparam logic [7:0] FIN_UP    = "A";
  localparam logic [7:0] FIN_DOWN  = "B";
  localparam logic [7:0] FIN_RIGHT = "C";
  localparam logic [7:0] FIN_LEFT  = "D";
  localparam logic [7:0] FIN_HOME  = "H";
  localparam logic [7:0] FIN_END   = "F";

  typedef struct packed {
    logic [3:0] key_code;
    logic [8:0] last_char;
  } key_result_t;

  key_result_t keys_due[$];

  logic [15:0] timeout_ticks;
  logic [1:0]  mode;
  logic [15:0] idle_ticks;
  logic [3:0]  kept;
  logic [7:0]  number;
  logic        number_done;
  logic [8:0]  saved_char;
  int          errors;
  int          n_checked;

  function automatic logic printable(input logic [7:0] b);
    return (b >= tekd_pkg::CH_SPACE) && (b <= tekd_pkg::CH_TILDE);
  endfunction

  function automatic logic [3:0] letter_key(input logic [7:0] b);
    case (b)
      FIN_UP:    return tekd_pkg::KC_UP;
      FIN_DOWN:  return tekd_pkg::KC_DOWN;
      FIN_RIGHT: return tekd_pkg::KC_RIGHT;
      FIN_LEFT:  return tekd_pkg::KC_LEFT;
      FIN_HOME:  return tekd_pkg::KC_HOME;
      FIN_END:   return tekd_pkg::KC_END;
      default:   return tekd_pkg::KC_NONE;
    endcase
  endfunction

  // advances the decode state by one request; high when a key comes out
  function automatic logic decode_request(input logic cmd, input logic [7:0] b,
                                          output logic [3:0] key);
    logic [15:0] lim;
    logic [11:0] prod;
    key = tekd_pkg::KC_NONE;
    if (cmd == tekd_pkg::CMD_TICK) begin
      if (mode == tekd_pkg::MODE_IDLE) return 1'b0;
      lim = (timeout_ticks == 16'd0) ? 16'd1 : timeout_ticks;
      if (idle_ticks != tekd_pkg::WAIT_MAX) idle_ticks++;
      if (idle_ticks < lim) return 1'b0;
      key = (mode == tekd_pkg::MODE_ESC) ? tekd_pkg::KC_ESC : tekd_pkg::KC_NONE;
      mode = tekd_pkg::MODE_IDLE;
      idle_ticks = '0;
      return 1'b1;
    end
    idle_ticks = '0;
    case (mode)
      tekd_pkg::MODE_IDLE: begin
        if (b == tekd_pkg::CH_ESC) begin
          mode = tekd_pkg::MODE_ESC;
          return 1'b0;
        end
        if (b == tekd_pkg::CH_CR || b == tekd_pkg::CH_LF) begin
          key = tekd_pkg::KC_ENTER;
        end else if (b == tekd_pkg::CH_DEL || b == tekd_pkg::CH_BS) begin
          key = tekd_pkg::KC_BACK;
        end else if (printable(b)) begin
          saved_char = {1'b0, b};
          key = tekd_pkg::KC_CHAR;
        end
      end
      tekd_pkg::MODE_ESC: begin
        if (b == tekd_pkg::CH_SS3) begin
          mode = tekd_pkg::MODE_SS3;
          return 1'b0;
        end
        if (b == tekd_pkg::CH_CSI) begin
          mode = tekd_pkg::MODE_CSI;
          kept = '0;
          number = '0;
          number_done = 1'b0;
          return 1'b0;
        end
        saved_char = {1'b0, b};
        key = printable(b) ? tekd_pkg::KC_CHAR : tekd_pkg::KC_ESC;
      end
      tekd_pkg::MODE_SS3: key = letter_key(b);
      default: begin
        if ((b >= tekd_pkg::CH_ZERO && b <= tekd_pkg::CH_NINE) || b == tekd_pkg::CH_SEMI) begin
          if (kept < MAX_PARAM_BYTES) begin
            kept++;
            if (!number_done) begin
              if (b == tekd_pkg::CH_SEMI) begin
                number_done = 1'b1;
              end else begin
                prod = number * 12'd10 + 12'(b - tekd_pkg::CH_ZERO);
                number = (prod > 12'(tekd_pkg::NUM_MAX)) ? tekd_pkg::NUM_MAX : prod[7:0];
              end
            end
          end
          return 1'b0;
        end
        if (b == tekd_pkg::CH_TILDE) begin
          case (number)
            8'd1, 8'd7: key = tekd_pkg::KC_HOME;
            8'd4, 8'd8: key = tekd_pkg::KC_END;
            8'd5:       key = tekd_pkg::KC_PGUP;
            8'd6:       key = tekd_pkg::KC_PGDN;
            8'd3:       key = tekd_pkg::KC_BACK;
            default:    key = tekd_pkg::KC_NONE;
          endcase
        end else begin
          key = letter_key(b);
        end
      end
    endcase
    mode = tekd_pkg::MODE_IDLE;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    logic [3:0]  key;
    key_result_t due;
    if (rst) begin
      timeout_ticks = tekd_pkg::TIMEOUT_RESET;
      mode = tekd_pkg::MODE_IDLE;
      idle_ticks = '0;
      kept = '0;
      number = '0;
      number_done = 1'b0;
      saved_char = tekd_pkg::CHAR_NONE;
      keys_due.delete();
    end else begin
      if (cfg_wen) timeout_ticks = cfg_wdata;
      if (s_axis_tvalid && s_axis_tready) begin
        if (decode_request(s_axis_tuser, s_axis_tdata, key))
          keys_due.push_back('{key_code: key, last_char: saved_char});
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (keys_due.size() == 0) begin
          $error("key with no request behind it: tdata %h", m_axis_tdata);
          errors++;
        end else begin
          due = keys_due.pop_front();
          n_checked++;
          if (m_axis_tdata[3:0] !== due.key_code) begin
            $error("key_code: expected %0d, got %0d", due.key_code, m_axis_tdata[3:0]);
            errors++;
          end
          if (m_axis_tdata[12:4] !== due.last_char) begin
            $error("last_char: expected %h, got %h", due.last_char, m_axis_tdata[12:4]);
            errors++;
          end
          if (m_axis_tdata[15:13] !== 3'b000) begin
            $error("pad: expected 0, got %b", m_axis_tdata[15:13]);
            errors++;
          end
        end
      end
    end
    fail_count   <= errors;
    keys_pending <= keys_due.size();
    keys_checked <= n_checked;
  end

endmodule

/* dv/tb.sv */
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the terminal key decoder.
// A directed pass walks the plain keys, alt and escape keys, SS3 and CSI
// finals, tilde numbers, saturation, dropped parameter bytes and timeouts;
// random phases then send mostly well-formed sequences with random content
// under several timeout settings, with bursty requests and stalled keys.
// ---------------------------------------------------------------------------
module tb;

  localparam int PARAM_BYTES = 7;
  localparam int CYCLE_LIMIT = 3_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // data_byte
  logic        s_axis_tuser = 1'b0; // command
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;        // key_code[3:0], last_char[12:4], zero[15:13]

  int          fail_count;
  int          keys_pending;
  int          keys_checked;
  int          cycles = 0;
  logic [7:0]  stall_phase = '0;
  int          burst_left = 0;
  int          bytes_sent = 0;
  int          expiries = 0;
  int          settings_run = 1;
  logic [15:0] timeout_now = tekd_pkg::TIMEOUT_RESET;

  always #5 clk = ~clk;

  terminal_escape_key_decoder_core #(
    .MAX_PARAM_BYTES(PARAM_BYTES)
  ) u_top (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  tekd_key_checker #(
    .MAX_PARAM_BYTES(PARAM_BYTES)
  ) u_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count    (fail_count),
    .keys_pending  (keys_pending),
    .keys_checked  (keys_checked)
  );

  // key sink stalls in windows of differing density
  always @(posedge clk) begin
    stall_phase <= stall_phase + 8'd1;
    case (stall_phase[7:6])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= ($urandom_range(0, 1) == 1);
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= stall_phase[2];
    endcase
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // one request, sent in bursts with random gaps between them
  task automatic send_req(input logic cmd, input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= cmd;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    burst_left--;
    if (cmd == tekd_pkg::CMD_BYTE) bytes_sent++;
  endtask

  task automatic send_str(input string s);
    for (int i = 0; i < s.len(); i++) send_req(tekd_pkg::CMD_BYTE, s[i]);
  endtask

  task automatic send_ticks(input int n);
    for (int i = 0; i < n; i++) send_req(tekd_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
  endtask

  // enough ticks to end whatever is pending
  task automatic expire_pending();
    send_ticks((timeout_now == 16'd0) ? 1 : int'(timeout_now));
    expiries++;
  endtask

  // stray ticks inside a sequence, mostly too few to end it
  task automatic maybe_ticks();
    int lim;
    lim = (timeout_now == 16'd0) ? 1 : int'(timeout_now);
    if ($urandom_range(0, 9) == 0) send_ticks($urandom_range(1, (lim + 1 < 40) ? lim + 1 : 40));
  endtask

  task automatic send_csi_params();
    int n;
    if ($urandom_range(0, 1) == 0) begin
      send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 2) == 0) begin
        send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_SEMI);
        send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
    end else begin
      n = $urandom_range(0, 10);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 5) == 0) send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_SEMI);
        else send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        maybe_ticks();
      end
    end
  endtask

  task automatic send_random_sequence();
    string finals;
    int    pick;
    finals = "ABCDHF~~~~RZ";
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(32, 126)));
    end else if (pick < 35) begin
      case ($urandom_range(0, 5))
        0:       send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_CR);
        1:       send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_LF);
        2:       send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_DEL);
        3:       send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_BS);
        4:       send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(0, 31)));
        default: send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(127, 255)));
      endcase
    end else if (pick < 45) begin
      send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      maybe_ticks();
      send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
    end else if (pick < 60) begin
      send_str("\033O");
      maybe_ticks();
      if ($urandom_range(0, 4) == 0) send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      else send_req(tekd_pkg::CMD_BYTE, finals[$urandom_range(0, 5)]);
    end else if (pick < 88) begin
      send_str("\033[");
      maybe_ticks();
      send_csi_params();
      if ($urandom_range(0, 7) == 0) send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
      else send_req(tekd_pkg::CMD_BYTE, finals[$urandom_range(0, finals.len() - 1)]);
    end else if (pick < 93) begin
      send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
      case ($urandom_range(0, 2))
        0:       send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_SS3);
        1:       begin
          send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_CSI);
          send_csi_params();
        end
        default: ;
      endcase
      expire_pending();
    end else begin
      if ($urandom_range(0, 1) == 0) send_ticks($urandom_range(1, 3));
      else send_req(tekd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_random(input int quota);
    int stop_at;
    stop_at = bytes_sent + quota;
    while (bytes_sent < stop_at) send_random_sequence();
  endtask

  // lets every due key come out and the pipeline settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (keys_pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_timeout(input logic [15:0] v);
    cfg_wen   <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    timeout_now = v;
    settings_run++;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // plain keys, ignored control bytes and byte extremes
    send_str("\r\n\177\010");
    send_req(tekd_pkg::CMD_BYTE, 8'h00);
    send_req(tekd_pkg::CMD_BYTE, 8'hFF);
    send_str(" ~");
    send_ticks(1);
    // alt key, escape with a control byte, lone escape timing out
    send_str("\033a");
    send_str("\033\001");
    send_req(tekd_pkg::CMD_BYTE, tekd_pkg::CH_ESC);
    expire_pending();
    // ss3 finals and timeout
    send_str("\033OA");
    send_str("\033OZ");
    send_str("\033O");
    expire_pending();
    // csi letters, tilde numbers, saturation, dropped bytes, cursor report
    send_str("\033[D");
    send_str("\033[3~\033[5~\033[6~\033[7~\033[8~\033[~");
    send_str("\033[999~");
    send_str("\033[00000005~");
    send_str("\033[24;80R");
    send_str("\033[12");
    expire_pending();
    drain();

    write_timeout(16'd1);
    run_random(200);
    drain();
    write_timeout(16'd0);
    run_random(150);
    drain();
    write_timeout(16'd100);
    send_str("\033[5");
    expire_pending();
    run_random(100);
    drain();
    write_timeout(16'($urandom_range(2, 40)));
    run_random(300);
    drain();
    write_timeout(tekd_pkg::TIMEOUT_RESET);
    run_random(250);
    drain();

    $display("sent %0d bytes over %0d timeout settings, %0d forced timeouts",
             bytes_sent, settings_run, expiries);
    $display("%0d keys compared against the prediction", keys_checked);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
